[rtl/core/card_access_occupancy_controller_defines.svh]
// Assertion helpers shared by the controller RTL.
`ifndef CARD_ACCESS_OCCUPANCY_CONTROLLER_DEFINES_SVH
`define CARD_ACCESS_OCCUPANCY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CAO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cao same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CAO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cao next-cycle check failed");

`endif

[rtl/core/cao_pkg.sv]
`default_nettype none

package cao_pkg;

  // Field widths fixed by the port definition
  localparam int UID_HALF_W   = 64;
  localparam int LIGHT_W      = 8;
  localparam int TEMP_W       = 16;
  localparam int OCC_W        = 8;
  localparam int CARDS_OUT_W  = 4;

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OCCUPANCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THRESH   = 2'd2;

  localparam logic [OCC_W-1:0]   MAX_OCC_RESET     = 8'd5;
  localparam logic [LIGHT_W-1:0] LIGHT_THRESH_RESET = 8'd1;
  localparam logic [TEMP_W-1:0]  TEMP_THRESH_RESET  = 16'd400;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture the accepted input word
    logic eval;      // register the table lookup
    logic commit;    // apply the tick to the state, publish the result
  } cao_cmd_t;

endpackage

`default_nettype wire

[rtl/core/cao_ctrl.sv]
`default_nettype none

`include "card_access_occupancy_controller_defines.svh"

module cao_ctrl import cao_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output cao_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MATCH  = 3'b010,
    S_UPDATE = 3'b100
  } cao_state_t;

  cao_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load_in = (state_r == S_IDLE) && in_valid;
    cmd.eval    = (state_r == S_MATCH);
    cmd.commit  = (state_r == S_UPDATE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CAO_ASSERT_NEXT(a_accept_starts_lookup, clk, rst_n, (state_r == S_IDLE) && in_valid, state_r == S_MATCH)
  `CAO_ASSERT_NEXT(a_blocked_commit_waits, clk, rst_n, (state_r == S_UPDATE) && out_valid_r && out_stall, (state_r == S_UPDATE) && out_valid_r)
  `CAO_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid_r && (state_r == S_IDLE))
  `CAO_ASSERT_NOW(a_no_accept_while_busy, clk, rst_n, state_r != S_IDLE, in_stall)

endmodule

`default_nettype wire

[rtl/core/cao_dp.sv]
`default_nettype none

`include "card_access_occupancy_controller_defines.svh"

module cao_dp import cao_pkg::*; #(
  parameter int CARD_SLOTS = 10,
  parameter int ID_BITS    = 128,
  parameter int MISS_POLLS = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cao_cmd_t               cmd,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_card_present,
  input  wire logic [UID_HALF_W-1:0]  in_uid_low,
  input  wire logic [UID_HALF_W-1:0]  in_uid_high,
  input  wire logic                   in_button_level,
  input  wire logic [LIGHT_W-1:0]     in_light_sample,
  input  wire logic [TEMP_W-1:0]      in_temperature_raw,
  output logic                        out_enrolling,
  output logic                        out_gate_open,
  output logic                        out_green_lamp,
  output logic                        out_red_lamp,
  output logic                        out_light_lamp,
  output logic                        out_fan_on,
  output logic                        out_beep_pulse,
  output logic [OCC_W-1:0]            out_occupancy,
  output logic [CARDS_OUT_W-1:0]      out_stored_cards
);

  localparam int CntW  = $clog2(CARD_SLOTS + 1);
  localparam int IdxW  = (CARD_SLOTS > 1) ? $clog2(CARD_SLOTS) : 1;
  localparam int MissW = $clog2(MISS_POLLS + 1);

  // Configuration
  logic [OCC_W-1:0]   max_occ_r;
  logic [LIGHT_W-1:0] light_thr_r;
  logic [TEMP_W-1:0]  temp_thr_r;

  // Captured input word
  logic [2*UID_HALF_W-1:0] full_id;
  logic [ID_BITS-1:0]      id_r;
  logic                    present_r;
  logic                    button_r;
  logic [LIGHT_W-1:0]      light_r;
  logic [TEMP_W-1:0]       temp_r;

  // Card table and lookup
  logic [ID_BITS-1:0] table_r [CARD_SLOTS];
  logic               hit;
  logic               match_r;
  logic               tab_we;

  // Tick state
  logic             enroll_r, enroll_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt, occ_mid;
  logic             gate_r, gate_nxt;
  logic [MissW-1:0] miss_r, miss_nxt, miss_inc;
  logic             last_r, last_nxt;
  logic             ind_r, ind_nxt;
  logic             lit_r, lit_nxt;
  logic             green_r, green_nxt;
  logic             red_r, red_nxt;
  logic             lamp_r, lamp_nxt;
  logic             fan_r, fan_nxt;
  logic             beep_r, beep_nxt;
  logic             below, rising, known;

  assign full_id = {in_uid_high, in_uid_low};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_occ_r   <= MAX_OCC_RESET;
      light_thr_r <= LIGHT_THRESH_RESET;
      temp_thr_r  <= TEMP_THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_OCCUPANCY: max_occ_r   <= cfg_data[OCC_W-1:0];
        CFG_LIGHT_THRESH:  light_thr_r <= cfg_data[LIGHT_W-1:0];
        CFG_TEMP_THRESH:   temp_thr_r  <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_r      <= full_id[ID_BITS-1:0];
      present_r <= in_card_present;
      button_r  <= in_button_level;
      light_r   <= in_light_sample;
      temp_r    <= in_temperature_raw;
    end
  end

  // Compare against every filled slot in parallel
  always_comb begin
    hit = 1'b0;
    for (int n = 0; n < CARD_SLOTS; n++) begin
      if ((CntW'(n) < count_r) && (table_r[n] == id_r)) hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) match_r <= hit;
  end

  always_ff @(posedge clk) begin
    if (tab_we) table_r[count_r[IdxW-1:0]] <= id_r;
  end

  assign below    = occ_r < max_occ_r;
  assign rising   = button_r && !last_r;
  assign known    = present_r && match_r;
  assign miss_inc = miss_r + 1'b1;

  always_comb begin
    enroll_nxt = enroll_r;
    count_nxt  = count_r;
    occ_mid    = occ_r;
    occ_nxt    = occ_r;
    gate_nxt   = gate_r;
    miss_nxt   = miss_r;
    last_nxt   = last_r;
    ind_nxt    = ind_r;
    lit_nxt    = lit_r;
    green_nxt  = green_r;
    red_nxt    = red_r;
    lamp_nxt   = lamp_r;
    fan_nxt    = fan_r;
    beep_nxt   = 1'b0;
    tab_we     = 1'b0;

    if (enroll_r) begin
      if (button_r) begin
        enroll_nxt = 1'b0;
      end else if (present_r && (count_r < CntW'(CARD_SLOTS)) && !match_r) begin
        tab_we    = cmd.commit;
        count_nxt = count_r + 1'b1;
        beep_nxt  = 1'b1;
      end
    end else begin
      last_nxt = button_r;

      // Indicators follow the occupancy seen before this tick
      if (!ind_r) begin
        if (below) begin
          green_nxt = 1'b1;
          red_nxt   = 1'b0;
          lit_nxt   = 1'b1;
          ind_nxt   = 1'b1;
        end
      end else if (!below) begin
        red_nxt   = 1'b1;
        green_nxt = 1'b0;
        ind_nxt   = 1'b0;
      end

      if (gate_r) begin
        if (known) begin
          miss_nxt = '0;
        end else if (miss_inc >= MissW'(MISS_POLLS)) begin
          miss_nxt = '0;
          gate_nxt = 1'b0;
        end else begin
          miss_nxt = miss_inc;
        end
      end else if (known && below) begin
        beep_nxt = 1'b1;
        gate_nxt = 1'b1;
        miss_nxt = '0;
        occ_mid  = occ_r + 1'b1;
      end

      lamp_nxt = light_r < light_thr_r;
      fan_nxt  = temp_r > temp_thr_r;

      if (rising && (occ_mid != '0)) occ_nxt = occ_mid - 1'b1;
      else occ_nxt = occ_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enroll_r <= 1'b1;
      count_r  <= '0;
      occ_r    <= '0;
      gate_r   <= 1'b1;
      miss_r   <= '0;
      last_r   <= 1'b0;
      ind_r    <= 1'b0;
      lit_r    <= 1'b0;
      green_r  <= 1'b0;
      red_r    <= 1'b0;
      lamp_r   <= 1'b0;
      fan_r    <= 1'b0;
      beep_r   <= 1'b0;
    end else if (cmd.commit) begin
      enroll_r <= enroll_nxt;
      count_r  <= count_nxt;
      occ_r    <= occ_nxt;
      gate_r   <= gate_nxt;
      miss_r   <= miss_nxt;
      last_r   <= last_nxt;
      ind_r    <= ind_nxt;
      lit_r    <= lit_nxt;
      green_r  <= green_nxt;
      red_r    <= red_nxt;
      lamp_r   <= lamp_nxt;
      fan_r    <= fan_nxt;
      beep_r   <= beep_nxt;
    end
  end

  // State changes only on commit, so it doubles as the held result word
  assign out_enrolling    = enroll_r;
  assign out_gate_open    = gate_r;
  assign out_green_lamp   = green_r && lit_r;
  assign out_red_lamp     = red_r && lit_r;
  assign out_light_lamp   = lamp_r;
  assign out_fan_on       = fan_r;
  assign out_beep_pulse   = beep_r;
  assign out_occupancy    = occ_r;
  assign out_stored_cards = CARDS_OUT_W'(count_r);

  `CAO_ASSERT_NEXT(a_enroll_never_returns, clk, rst_n, !enroll_r, !enroll_r)
  `CAO_ASSERT_NOW(a_table_bound, clk, rst_n, tab_we, count_r < CntW'(CARD_SLOTS))

endmodule

`default_nettype wire

[rtl/core/card_access_occupancy_controller.sv]
// One poll word at a time: accept, table lookup, state update; no new word
// is taken until its update commits. The result word is valid after the commit.
// The commit step waits while an earlier result is stalled at the output.
// Reset (rst_n low, synchronous): enrollment mode, empty table, gate open,
// occupancy zero, lamps and fan off, thresholds back to 5 / 1 / 400.
`default_nettype none

module card_access_occupancy_controller import cao_pkg::*; #(
  parameter int CARD_SLOTS = 10,
  parameter int ID_BITS    = 128,
  parameter int MISS_POLLS = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // poll words in
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_card_present,
  input  wire logic [UID_HALF_W-1:0]  in_uid_low,
  input  wire logic [UID_HALF_W-1:0]  in_uid_high,
  input  wire logic                   in_button_level,
  input  wire logic [LIGHT_W-1:0]     in_light_sample,
  input  wire logic [TEMP_W-1:0]      in_temperature_raw,
  // result words out
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_enrolling,
  output logic                        out_gate_open,
  output logic                        out_green_lamp,
  output logic                        out_red_lamp,
  output logic                        out_light_lamp,
  output logic                        out_fan_on,
  output logic                        out_beep_pulse,
  output logic [OCC_W-1:0]            out_occupancy,
  output logic [CARDS_OUT_W-1:0]      out_stored_cards
);

  cao_cmd_t cmd;

  // Sequencer: owns both handshakes and the result-valid flag
  cao_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: thresholds, card table, gate / occupancy / indicator state.
  // Its state registers hold the published result word until the next commit.
  cao_dp #(
    .CARD_SLOTS (CARD_SLOTS),
    .ID_BITS    (ID_BITS),
    .MISS_POLLS (MISS_POLLS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_card_present    (in_card_present),
    .in_uid_low         (in_uid_low),
    .in_uid_high        (in_uid_high),
    .in_button_level    (in_button_level),
    .in_light_sample    (in_light_sample),
    .in_temperature_raw (in_temperature_raw),
    .out_enrolling      (out_enrolling),
    .out_gate_open      (out_gate_open),
    .out_green_lamp     (out_green_lamp),
    .out_red_lamp       (out_red_lamp),
    .out_light_lamp     (out_light_lamp),
    .out_fan_on         (out_fan_on),
    .out_beep_pulse     (out_beep_pulse),
    .out_occupancy      (out_occupancy),
    .out_stored_cards   (out_stored_cards)
  );

endmodule

`default_nettype wire
